// ===== hdl/scit_pkg.sv =====
// Shared constants, types and controller codes for the set intersection counter.
package scit_pkg;

	localparam int SET_SIZE_DEF = 16;
	localparam int VAL_W        = 64;
	localparam int KEY_W        = 2 * VAL_W;
	localparam int CNT_W        = 9;
	localparam logic [CNT_W-1:0] COUNT_MAX     = '1;
	localparam logic [CNT_W-1:0] THRESHOLD_RST = CNT_W'(1);

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_COMPARE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} scit_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // write accepted word into the store
		logic start;  // capture compare key, rewind read address
		logic issue;  // read one store entry
		logic emit;   // load result register, clear pair count and load pointer
	} scit_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_end; // read address reached load pointer
		logic last;      // captured compare word was the final one
		logic out_free;  // result register can take a new word
	} scit_sts_t;

endpackage

// ===== hdl/scit_if.sv =====
// Valid/ready channel interfaces for input words and result words.
interface scit_item_if;
	import scit_pkg::*;
	logic             valid;
	logic             ready;
	logic             action;
	logic [VAL_W-1:0] value_low;
	logic [VAL_W-1:0] value_high;
	logic             last;

	modport source (output valid, output action, output value_low, output value_high,
		output last, input ready);
	modport sink (input valid, input action, input value_low, input value_high,
		input last, output ready);
endinterface

interface scit_result_if;
	import scit_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] pair_count;
	logic             is_match;

	modport source (output valid, output pair_count, output is_match, input ready);
	modport sink (input valid, input pair_count, input is_match, output ready);
endinterface

// ===== hdl/scit_ctrl.sv =====
// Controller state machine: accepts words, sequences the store sweep and result hand-off.
module scit_ctrl import scit_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic      item_action,
	input  scit_sts_t sts,
	output logic      item_ready,
	output scit_cmd_t cmd
);

	scit_state_t state_q;
	scit_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		item_ready = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item_action == ACT_COMPARE) begin
						cmd.start = 1'b1;
						state_nxt = ST_SWEEP;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_SWEEP: begin
				if (sts.sweep_end) begin
					state_nxt = ST_DONE;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			ST_DONE: begin
				if (!sts.last) begin
					state_nxt = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/scit_dp.sv =====
// Datapath: first-party store, compare key, sweep address, pair counter, result register.
module scit_dp import scit_pkg::*; #(
	parameter int SET_SIZE = SET_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  scit_cmd_t        cmd,
	output scit_sts_t        sts,
	input  logic [VAL_W-1:0] value_low,
	input  logic [VAL_W-1:0] value_high,
	input  logic             last,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CNT_W-1:0] out_pair_count,
	output logic             out_is_match
);

	localparam int PTR_W = $clog2(SET_SIZE + 1);
	localparam int IDX_W = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
	localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(SET_SIZE);

	logic [KEY_W-1:0] store_mem [SET_SIZE];

	logic [PTR_W-1:0] load_ptr_q;
	logic [PTR_W-1:0] addr_q;
	logic [KEY_W-1:0] key_q;
	logic             last_q;
	logic [KEY_W-1:0] rd_data_s1;
	logic             rd_vld_s1;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] thr_q;
	logic             out_vld_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             out_match_q;
	logic             hit;

	assign hit = rd_vld_s1 && (rd_data_s1 == key_q);

	assign sts.sweep_end = (addr_q == load_ptr_q);
	assign sts.last      = last_q;
	assign sts.out_free  = !out_vld_q || out_ready;

	// store write, registered read, compare key and result register capture
	always_ff @(posedge clk) begin
		if (cmd.load && (load_ptr_q != PTR_FULL)) begin
			store_mem[load_ptr_q[IDX_W-1:0]] <= {value_high, value_low};
		end
		if (cmd.issue) begin
			rd_data_s1 <= store_mem[addr_q[IDX_W-1:0]];
		end
		if (cmd.start) begin
			key_q <= {value_high, value_low};
		end
		if (cmd.emit) begin
			out_cnt_q   <= count_q;
			out_match_q <= (count_q >= thr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q <= '0;
			addr_q     <= '0;
			last_q     <= 1'b0;
			rd_vld_s1  <= 1'b0;
			count_q    <= '0;
			thr_q      <= THRESHOLD_RST;
			out_vld_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (cmd.start) begin
				addr_q <= '0;
				last_q <= last;
			end else if (cmd.issue) begin
				addr_q <= addr_q + PTR_W'(1);
			end
			if (cmd.emit) begin
				load_ptr_q <= '0;
				count_q    <= '0;
			end else begin
				if (cmd.load && (load_ptr_q != PTR_FULL)) begin
					load_ptr_q <= load_ptr_q + PTR_W'(1);
				end
				if (hit && (count_q != COUNT_MAX)) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_vld_q;
	assign out_pair_count = out_cnt_q;
	assign out_is_match   = out_match_q;

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load_ptr_q <= PTR_FULL)
		else $error("load pointer beyond store size");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (addr_q < load_ptr_q))
		else $error("store read past loaded entries");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_vld_q || out_ready))
		else $error("result word overwritten before taken");

	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.emit |=> (count_q >= $past(count_q)))
		else $error("pair count dropped without a result");

	a_no_read_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !rd_vld_s1)
		else $error("result taken while a compare is still in flight");

endmodule

// ===== hdl/set_intersection_count_threshold.sv =====
// Top level: counts equal 128-bit value pairs between two parties and tests a threshold.
//
//  channel  dir  handshake      payload
//  item     in   valid/ready    action, value_low, value_high, last
//  result   out  valid/ready    pair_count, is_match
//  cfg      in   cfg_we         cfg_wdata (match_threshold)
//
// Words are accepted only in idle; a compare word holds off the next word while the
// store, one memory, is swept one entry per cycle through a registered read port.
// Reset clears the load pointer, pair count and result valid; threshold resets to 1.
// The result register lets the next word in while a result waits; a final compare
// word waits in its last cycle until the result register is free.
module set_intersection_count_threshold import scit_pkg::*; #(
	parameter int SET_SIZE = SET_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	scit_item_if.sink        item,
	scit_result_if.source    result,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	scit_cmd_t cmd;
	scit_sts_t sts;

	scit_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_action (item.action),
		.sts         (sts),
		.item_ready  (item.ready),
		.cmd         (cmd)
	);

	scit_dp #(
		.SET_SIZE (SET_SIZE)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.value_low      (item.value_low),
		.value_high     (item.value_high),
		.last           (item.last),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.out_pair_count (result.pair_count),
		.out_is_match   (result.is_match)
	);

endmodule
